### design/imsu_pkg.sv
// ----------------------------------------------------------------------------
// imsu_pkg: shared definitions for the Ising spin update unit
// Field and stream widths, register indexes, reset values, item kinds and the sequencer states.
// ----------------------------------------------------------------------------
package imsu_pkg;

  // Default largest lattice side.
  localparam int MAX_SIDE_DEF = 64;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int SITE_W   = 12;
  localparam int RND_W    = 16;
  localparam int SIDE_W   = 7;
  localparam int THR_W    = 17;
  localparam int THR_REG_W = 34;
  localparam int UP_W     = 13;
  localparam int UNLIKE_W = 15;
  localparam int CELLS_W  = 14;
  localparam int ADD_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Stream widths.
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [SIDE_W-1:0]    SIDE_RESET = 7'd64;
  localparam logic [THR_REG_W-1:0] THR_RESET  = 34'd8590000128;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_UPDATE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_READ_ALT = 2'd3
  } item_kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LATTICE_SIDE = 3'd0,
    REG_ACCEPT_M4    = 3'd1,
    REG_ACCEPT_M2    = 3'd2,
    REG_ACCEPT_ZERO  = 3'd3,
    REG_ACCEPT_P2    = 3'd4,
    REG_ACCEPT_P4    = 3'd5
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } seq_state_t;

endpackage

### design/ising_metropolis_spin_update_unit.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_unit: Metropolis single-spin-flip engine
// Holds a square spin lattice with periodic wrap, applies update, load and
// read requests, and keeps running counts of up spins and unlike pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (kind in s_tuser, site, random word and
//   spin to load in s_tdata). Each request gives one result on the m_
//   channel. Thresholds and the lattice side are set through the plain write
//   port by the user while the block is idle, which it does not enforce.
// Sequence:
//   A valid site goes from acceptance to the result register through a
//   restoring division of the site by the side (one bit per cycle through
//   the shared adder), reads of the site and its four neighbors through
//   the single lattice memory port, evaluation and write-back, and the
//   load of the result; an out-of-range site goes straight to that load.
//   A new request is taken only once the last result is loaded, even
//   while that result still waits on the m_ channel.
// Reset:
//   rst clears the counts and control state, resets the configuration,
//   then a clearing pass writes every lattice entry to spin down.
//   No request is taken during the pass; configuration writes are.
// Stall:
//   While m_tready is low a finished result holds; the next result waits in
//   the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_unit #(
  parameter int MAX_SIDE = imsu_pkg::MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: site[11:0], random_word[27:12], spin_in[28], zeros.
  input  logic [imsu_pkg::S_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: kind[1:0].
  input  logic [imsu_pkg::KIND_W-1:0]       s_tuser,
  // Result channel.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: spin_out[0], flipped[1], up_spins[14:2],
  // unlike_pairs[29:15], bad_site[30], zero[31].
  output logic [imsu_pkg::M_DATA_W-1:0]     m_tdata,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imsu_pkg::THR_REG_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SIDE_CAP_I = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
  localparam logic [imsu_pkg::SIDE_W-1:0] SIDE_CAP = imsu_pkg::SIDE_W'(SIDE_CAP_I);
  localparam int RST_SIDE_I = (MAX_SIDE < 64) ? MAX_SIDE : 64;
  localparam logic [imsu_pkg::SIDE_W-1:0]  RST_SIDE  = imsu_pkg::SIDE_W'(RST_SIDE_I);
  localparam logic [imsu_pkg::CELLS_W-1:0] RST_CELLS =
    imsu_pkg::CELLS_W'(RST_SIDE_I * RST_SIDE_I);
  localparam logic [imsu_pkg::CELLS_W-1:0] RST_WRAP =
    imsu_pkg::CELLS_W'((RST_SIDE_I - 1) * RST_SIDE_I);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Configuration registers and values derived from the side.
  logic [imsu_pkg::SIDE_W-1:0]    side_use;
  logic [imsu_pkg::CELLS_W-1:0]   cells;
  logic [imsu_pkg::CELLS_W-1:0]   wrap_span;
  logic [imsu_pkg::THR_REG_W-1:0] accept_reg [5];

  // Sequencer and working registers.
  imsu_pkg::seq_state_t state, state_next;
  logic [AW-1:0]                  clr_addr;
  imsu_pkg::item_kind_t           kind_q;
  logic [imsu_pkg::SITE_W-1:0]    site_q;
  logic [imsu_pkg::RND_W-1:0]     rnd_q;
  logic                           spin_in_q;
  logic                           bad_q;
  logic                           flip_q;
  logic                           spin_q;
  logic [imsu_pkg::SITE_W-1:0]    dvd;
  logic [imsu_pkg::SITE_W-1:0]    quo;
  logic [imsu_pkg::SIDE_W-1:0]    rem;
  logic [3:0]                     step;
  logic [2:0]                     rd_idx;
  logic [4:0]                     seen;
  logic [imsu_pkg::UP_W-1:0]      up_count;
  logic [imsu_pkg::UNLIKE_W-1:0]  unlike_count;

  // Lattice memory.
  logic                           mem [DEPTH];
  logic                           rd_data;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic                           wr_en;
  logic                           wr_data;

  // Shared adder.
  logic [imsu_pkg::ADD_W-1:0]     alu_a;
  logic [imsu_pkg::ADD_W-1:0]     alu_b;
  logic [imsu_pkg::ADD_W-1:0]     alu_sum;

  logic                           accept;
  logic                           out_free;
  logic                           in_bad;
  logic [imsu_pkg::SIDE_W-1:0]    side_new;
  logic [imsu_pkg::ADD_W-1:0]     side_ext;
  logic [imsu_pkg::ADD_W-1:0]     sm1_ext;
  logic [imsu_pkg::ADD_W-1:0]     wrap_ext;
  logic                           col_first;
  logic                           col_last;
  logic                           row_first;
  logic                           row_last;
  logic [2:0]                     ups;
  logic [2:0]                     likes;
  logic [imsu_pkg::THR_REG_W-1:0] thr_reg;
  logic [imsu_pkg::THR_W-1:0]     thr;
  logic                           do_flip;
  logic [imsu_pkg::UNLIKE_W-1:0]  unlike_delta;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == imsu_pkg::ST_IDLE);

  // A site is out of range when it is not below L*L or beyond the store.
  assign in_bad = ({2'b00, s_tdata[imsu_pkg::SITE_W-1:0]} >= cells) ||
                  (32'(s_tdata[imsu_pkg::SITE_W-1:0]) >= DEPTH);

  // Side value clipped to the largest lattice.
  assign side_new = (32'(cfg_data[imsu_pkg::SIDE_W-1:0]) > MAX_SIDE) ?
                    SIDE_CAP : cfg_data[imsu_pkg::SIDE_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_use     <= RST_SIDE;
      cells        <= RST_CELLS;
      wrap_span    <= RST_WRAP;
      for (int i = 0; i < 5; i++) begin
        accept_reg[i] <= imsu_pkg::THR_RESET;
      end
    end else if (cfg_we) begin
      case (imsu_pkg::cfg_reg_t'(cfg_index))
        imsu_pkg::REG_LATTICE_SIDE: begin
          side_use     <= side_new;
          cells        <= {7'b0, side_new} * {7'b0, side_new};
          wrap_span    <= {7'b0, side_new - 7'd1} * {7'b0, side_new};
        end
        imsu_pkg::REG_ACCEPT_M4:   accept_reg[0] <= cfg_data;
        imsu_pkg::REG_ACCEPT_M2:   accept_reg[1] <= cfg_data;
        imsu_pkg::REG_ACCEPT_ZERO: accept_reg[2] <= cfg_data;
        imsu_pkg::REG_ACCEPT_P2:   accept_reg[3] <= cfg_data;
        imsu_pkg::REG_ACCEPT_P4:   accept_reg[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wrap conditions from the division result.
  assign side_ext  = {9'b0, side_use};
  assign sm1_ext   = {9'b0, side_use - 7'd1};
  assign wrap_ext  = {2'b0, wrap_span};
  assign col_first = (rem == '0);
  assign col_last  = (rem == side_use - 7'd1);
  assign row_first = (quo == '0);
  assign row_last  = (quo == {5'b0, side_use - 7'd1});

  // Operand selection for the shared adder: division trial or neighbor offset.
  always_comb begin
    alu_a = {4'b0, site_q};
    alu_b = '0;
    case (state)
      imsu_pkg::ST_DIV: begin
        alu_a = {8'b0, rem, dvd[imsu_pkg::SITE_W-1]};
        alu_b = '0 - side_ext;
      end
      imsu_pkg::ST_READ: begin
        case (rd_idx)
          3'd1:    alu_b = col_last  ? ('0 - sm1_ext)  : 16'd1;
          3'd2:    alu_b = col_first ? sm1_ext         : 16'hFFFF;
          3'd3:    alu_b = row_last  ? ('0 - wrap_ext) : side_ext;
          3'd4:    alu_b = row_first ? wrap_ext        : ('0 - side_ext);
          default: alu_b = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign alu_sum = alu_a + alu_b;
  assign rd_addr = alu_sum[AW-1:0];

  // Acceptance decision from the captured spins.
  assign ups   = 3'(seen[1]) + 3'(seen[2]) + 3'(seen[3]) + 3'(seen[4]);
  assign likes = seen[0] ? ups : 3'd4 - ups;

  always_comb begin
    case (ups)
      3'd0:    thr_reg = accept_reg[0];
      3'd1:    thr_reg = accept_reg[1];
      3'd2:    thr_reg = accept_reg[2];
      3'd3:    thr_reg = accept_reg[3];
      default: thr_reg = accept_reg[4];
    endcase
  end

  assign thr = seen[0] ? thr_reg[imsu_pkg::THR_W-1:0] :
                         thr_reg[imsu_pkg::THR_REG_W-1:imsu_pkg::THR_W];

  always_comb begin
    case (kind_q)
      imsu_pkg::KIND_UPDATE: do_flip = ({1'b0, rnd_q} < thr);
      imsu_pkg::KIND_LOAD:   do_flip = (seen[0] != spin_in_q);
      default:               do_flip = 1'b0;
    endcase
  end

  // Unlike pairs change by 2*like - 2*unlike; a side of one has no real pairs.
  assign unlike_delta = (side_use == 7'd1) ? '0 :
                        ({10'b0, likes, 2'b00} - 15'd8);

  // Memory write: clearing pass or flip write-back.
  assign wr_en   = (state == imsu_pkg::ST_CLEAR) ||
                   ((state == imsu_pkg::ST_EVAL) && do_flip);
  assign wr_addr = (state == imsu_pkg::ST_CLEAR) ? clr_addr : AW'(site_q);
  assign wr_data = (state == imsu_pkg::ST_CLEAR) ? 1'b0 : !seen[0];

  // Lattice memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      imsu_pkg::ST_CLEAR: if (clr_addr == LAST_ADDR) state_next = imsu_pkg::ST_IDLE;
      imsu_pkg::ST_IDLE: begin
        if (accept) state_next = in_bad ? imsu_pkg::ST_DONE : imsu_pkg::ST_DIV;
      end
      imsu_pkg::ST_DIV:  if (step == 4'd11) state_next = imsu_pkg::ST_READ;
      imsu_pkg::ST_READ: if (rd_idx == 3'd5) state_next = imsu_pkg::ST_EVAL;
      imsu_pkg::ST_EVAL: state_next = imsu_pkg::ST_DONE;
      imsu_pkg::ST_DONE: if (out_free) state_next = imsu_pkg::ST_IDLE;
      default:           state_next = imsu_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= imsu_pkg::ST_CLEAR;
      clr_addr     <= '0;
      up_count     <= '0;
      unlike_count <= '0;
      m_tvalid     <= 1'b0;
      step         <= '0;
      rd_idx       <= '0;
    end else begin
      state <= state_next;
      if (state == imsu_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == imsu_pkg::ST_IDLE) begin
        step   <= '0;
        rd_idx <= '0;
      end
      if (state == imsu_pkg::ST_DIV) begin
        step <= step + 4'd1;
      end
      if (state == imsu_pkg::ST_READ) begin
        rd_idx <= rd_idx + 3'd1;
      end
      if ((state == imsu_pkg::ST_EVAL) && do_flip) begin
        unlike_count <= unlike_count + unlike_delta;
        up_count     <= seen[0] ? up_count - 13'd1 : up_count + 13'd1;
      end
      if ((state == imsu_pkg::ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= imsu_pkg::item_kind_t'(s_tuser);
      site_q    <= s_tdata[imsu_pkg::SITE_W-1:0];
      rnd_q     <= s_tdata[imsu_pkg::SITE_W +: imsu_pkg::RND_W];
      spin_in_q <= s_tdata[imsu_pkg::SITE_W + imsu_pkg::RND_W];
      bad_q     <= in_bad;
      flip_q    <= 1'b0;
      spin_q    <= 1'b0;
      dvd       <= s_tdata[imsu_pkg::SITE_W-1:0];
      quo       <= '0;
      rem       <= '0;
    end
    // One restoring division step per cycle.
    if (state == imsu_pkg::ST_DIV) begin
      dvd <= {dvd[imsu_pkg::SITE_W-2:0], 1'b0};
      quo <= {quo[imsu_pkg::SITE_W-2:0], !alu_sum[imsu_pkg::ADD_W-1]};
      rem <= alu_sum[imsu_pkg::ADD_W-1] ? {rem[imsu_pkg::SIDE_W-2:0],
                                           dvd[imsu_pkg::SITE_W-1]}
                                        : alu_sum[imsu_pkg::SIDE_W-1:0];
    end
    // Read data arrives in the cycle after its address.
    if ((state == imsu_pkg::ST_READ) && (rd_idx != 3'd0)) begin
      seen[rd_idx - 3'd1] <= rd_data;
    end
    if (state == imsu_pkg::ST_EVAL) begin
      flip_q <= do_flip;
      spin_q <= seen[0] ^ do_flip;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if ((state == imsu_pkg::ST_DONE) && out_free) begin
      m_tdata <= {1'b0, bad_q, unlike_count, up_count, flip_q, spin_q};
    end
  end

endmodule
